// ----- rtl/core/kie_pkg.sv -----
`default_nettype none
package kie_pkg;

  // Longest k-mer window held by the block
  localparam int MAX_WORD = 20;
  // Bits that can hold a count from 0 to MAX_WORD
  localparam int WORD_W = $clog2(MAX_WORD + 1);
  // Counter width, at least as wide as the word_size register
  localparam int COUNT_W = (WORD_W > 5) ? WORD_W : 5;

  localparam int CODE_W = 5;
  localparam int ACC_W  = 31;
  localparam int PROD_W = ACC_W + CODE_W;
  localparam int POS_W  = 32;

  localparam logic [ACC_W-1:0] IDX_MAX = {ACC_W{1'b1}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_GAPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_HI  = 3'd5;

  // Alphabet modes; any other code behaves as reduced
  localparam logic [1:0] MODE_NUCLEOTIDE = 2'd0;
  localparam logic [1:0] MODE_AMINO      = 2'd1;

  // Gap bytes
  localparam logic [7:0] NUC_GAP_A   = 8'd16;
  localparam logic [7:0] NUC_GAP_B   = 8'd64;
  localparam logic [7:0] AMINO_GAP_A = 8'd45;
  localparam logic [7:0] AMINO_GAP_B = 8'd46;

  // Mapped symbol
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              known;
    logic              gap;
  } kie_sym_t;

  // One request travelling down the cell chain
  typedef struct packed {
    logic [MAX_WORD-1:0][CODE_W-1:0] codes;  // head is the next code to fold in
    logic [MAX_WORD-1:0]             unk;
    logic [WORD_W-1:0]               left;   // Horner steps still to do
    logic [ACC_W-1:0]                acc;
    logic                            ovf;
    logic                            amb;
    logic [POS_W-1:0]                position;
    logic                            last;
  } kie_item_t;

  // Amino-acid rank of an ASCII letter: {valid, rank}
  function automatic logic [CODE_W:0] amino_rank(input logic [7:0] sym);
    logic [CODE_W:0] r;
    unique case (sym)
      8'd65:   r = {1'b1, 5'd0};   // A
      8'd82:   r = {1'b1, 5'd1};   // R
      8'd78:   r = {1'b1, 5'd2};   // N
      8'd68:   r = {1'b1, 5'd3};   // D
      8'd67:   r = {1'b1, 5'd4};   // C
      8'd81:   r = {1'b1, 5'd5};   // Q
      8'd69:   r = {1'b1, 5'd6};   // E
      8'd71:   r = {1'b1, 5'd7};   // G
      8'd72:   r = {1'b1, 5'd8};   // H
      8'd73:   r = {1'b1, 5'd9};   // I
      8'd76:   r = {1'b1, 5'd10};  // L
      8'd75:   r = {1'b1, 5'd11};  // K
      8'd77:   r = {1'b1, 5'd12};  // M
      8'd70:   r = {1'b1, 5'd13};  // F
      8'd80:   r = {1'b1, 5'd14};  // P
      8'd83:   r = {1'b1, 5'd15};  // S
      8'd84:   r = {1'b1, 5'd16};  // T
      8'd87:   r = {1'b1, 5'd17};  // W
      8'd89:   r = {1'b1, 5'd18};  // Y
      8'd86:   r = {1'b1, 5'd19};  // V
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kmer_index_enumerator_top.sv -----
`default_nettype none
// Rolling k-mer index over a stream of sequence bytes.
// Input channel (in_valid/in_ready): one symbol byte and a seq_end mark per
// request. Output channel (out_valid/out_ready): at most one result per input,
// with kmer_value, ambiguous, overflowed, position and seq_last.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while no result is outstanding.
// Throughput: one symbol per cycle, sustained while results are taken. The
// index is folded by a chain of MAX_WORD cells, at most one multiply-add
// Horner step per cell; every result passes all MAX_WORD cell registers,
// whatever the word size. Symbols that yield no result (window not full,
// dropped gaps) leave a bubble in the chain; only the former shift the window.
// Stalls: when out_ready is low with a result waiting, the whole chain
// holds and in_ready drops until the result is taken.
// Reset: synchronous, active high; clears the chain, the fill count and the
// position, and restores word_size 4, radix 4, nucleotide mode, no gap
// skipping and zero reduced tables.
module kmer_index_enumerator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  symbol,
  input  wire logic        seq_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      kmer_value,
  output logic             ambiguous,
  output logic             overflowed,
  output logic [31:0]      position,
  output logic             seq_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [kie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int N = kie_pkg::MAX_WORD;

  logic [4:0]  word_size;
  logic [4:0]  radix;
  logic [1:0]  alphabet_mode;
  logic        skip_gaps;
  logic [59:0] reduced_map_low;
  logic [39:0] reduced_map_high;

  logic               advance;
  logic               accept;
  logic               emit;
  kie_pkg::kie_sym_t  sym;
  kie_pkg::kie_item_t chain_item [N+1];
  logic               chain_vld  [N+1];
  kie_pkg::kie_item_t res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_size        <= 5'd4;
      radix            <= 5'd4;
      alphabet_mode    <= kie_pkg::MODE_NUCLEOTIDE;
      skip_gaps        <= 1'b0;
      reduced_map_low  <= '0;
      reduced_map_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kie_pkg::CFG_WORD_SIZE:   word_size        <= cfg_data[4:0];
        kie_pkg::CFG_RADIX:       radix            <= cfg_data[4:0];
        kie_pkg::CFG_ALPHABET:    alphabet_mode    <= cfg_data[1:0];
        kie_pkg::CFG_SKIP_GAPS:   skip_gaps        <= cfg_data[0];
        kie_pkg::CFG_REDUCED_LOW: reduced_map_low  <= cfg_data[59:0];
        kie_pkg::CFG_REDUCED_HI:  reduced_map_high <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Chain moves unless a finished result is held back
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  kie_map u_map (
    .symbol           (symbol),
    .alphabet_mode    (alphabet_mode),
    .reduced_map_low  (reduced_map_low),
    .reduced_map_high (reduced_map_high),
    .sym              (sym)
  );

  kie_window u_window (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .skip_gaps (skip_gaps),
    .word_size (word_size),
    .seq_end   (seq_end),
    .sym       (sym),
    .emit      (emit),
    .entry     (chain_item[0])
  );

  assign chain_vld[0] = emit;

  // Horner cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    kie_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .radix    (radix),
      .in_vld   (chain_vld[k]),
      .in_item  (chain_item[k]),
      .out_vld  (chain_vld[k+1]),
      .out_item (chain_item[k+1])
    );
  end

  // Result from the last cell
  assign res        = chain_item[N];
  assign out_valid  = chain_vld[N];
  assign ambiguous  = res.amb;
  assign kmer_value = res.amb ? '0 : res.acc;
  assign overflowed = res.amb ? 1'b0 : res.ovf;
  assign position   = res.position;
  assign seq_last   = res.last;

  // Every Horner step has been taken by the end of the chain
  a_steps_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.left == '0))
    else $error("result leaves chain with steps pending");

  a_amb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ambiguous |-> (kmer_value == '0) && !overflowed)
    else $error("ambiguous result carries a value");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> (kmer_value == kie_pkg::IDX_MAX))
    else $error("overflowed result not saturated");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position != '0))
    else $error("result position is zero");

endmodule
`default_nettype wire

// ----- rtl/core/kie_map.sv -----
`default_nettype none
module kie_map (
  input  wire logic [7:0]  symbol,
  input  wire logic [1:0]  alphabet_mode,
  input  wire logic [59:0] reduced_map_low,
  input  wire logic [39:0] reduced_map_high,
  output kie_pkg::kie_sym_t sym
);

  logic [kie_pkg::CODE_W:0] rank;
  logic [3:0]               r_low;
  logic [2:0]               r_high;

  assign rank   = kie_pkg::amino_rank(symbol);
  assign r_low  = rank[3:0];
  assign r_high = 3'(rank[4:0] - 5'd12);

  // Letter code and gap detection
  always_comb begin
    sym = '0;
    if (alphabet_mode == kie_pkg::MODE_NUCLEOTIDE) begin
      sym.gap = (symbol == kie_pkg::NUC_GAP_A) || (symbol == kie_pkg::NUC_GAP_B);
      unique case (symbol)
        8'd1:    begin sym.code = 5'd0; sym.known = 1'b1; end
        8'd2:    begin sym.code = 5'd1; sym.known = 1'b1; end
        8'd4:    begin sym.code = 5'd2; sym.known = 1'b1; end
        8'd8:    begin sym.code = 5'd3; sym.known = 1'b1; end
        default: begin sym.code = 5'd0; sym.known = 1'b0; end
      endcase
    end else begin
      sym.gap   = (symbol == kie_pkg::AMINO_GAP_A) || (symbol == kie_pkg::AMINO_GAP_B);
      sym.known = rank[kie_pkg::CODE_W];
      if (!rank[kie_pkg::CODE_W]) begin
        sym.code = '0;
      end else if (alphabet_mode == kie_pkg::MODE_AMINO) begin
        sym.code = rank[kie_pkg::CODE_W-1:0];
      end else if (rank[4:0] < 5'd12) begin
        sym.code = reduced_map_low[r_low * 5 +: 5];
      end else begin
        sym.code = reduced_map_high[r_high * 5 +: 5];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/kie_window.sv -----
`default_nettype none
module kie_window (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             skip_gaps,
  input  wire logic [4:0]       word_size,
  input  wire logic             seq_end,
  input  wire kie_pkg::kie_sym_t sym,
  output logic                  emit,
  output kie_pkg::kie_item_t    entry
);

  localparam int CW = kie_pkg::COUNT_W;

  // Codes and flags need no clearing: only entries written since the
  // last sequence end are ever read, the fill count guards the rest.
  logic [kie_pkg::MAX_WORD-1:0][kie_pkg::CODE_W-1:0] codes, codes_next;
  logic [kie_pkg::MAX_WORD-1:0]                      unk, unk_next;
  logic [CW-1:0]          fill_count, fill_next;
  logic [kie_pkg::POS_W-1:0] symbol_index, index_next;
  logic [CW-1:0]          ws_ext, ws_eff;
  logic                   drop;

  // Clamp word size into 1..MAX_WORD
  always_comb begin
    ws_ext = CW'(word_size);
    if (ws_ext == '0) begin
      ws_eff = CW'(1);
    end else if (ws_ext > CW'(kie_pkg::MAX_WORD)) begin
      ws_eff = CW'(kie_pkg::MAX_WORD);
    end else begin
      ws_eff = ws_ext;
    end
  end

  assign drop       = skip_gaps && sym.gap;
  assign index_next = (symbol_index == '1) ? symbol_index : symbol_index + 1'b1;
  assign fill_next  = (fill_count >= CW'(kie_pkg::MAX_WORD)) ? fill_count
                                                             : fill_count + 1'b1;

  // Window after shifting in the new code
  always_comb begin
    codes_next[0] = sym.code;
    unk_next[0]   = !sym.known;
    for (int j = 1; j < kie_pkg::MAX_WORD; j++) begin
      codes_next[j] = codes[j-1];
      unk_next[j]   = unk[j-1];
    end
  end

  assign emit = accept && !drop && (fill_next >= ws_eff);

  // Request that enters the chain
  always_comb begin
    entry          = '0;
    entry.codes    = codes_next;
    entry.unk      = unk_next;
    entry.left     = kie_pkg::WORD_W'(ws_eff);
    entry.position = index_next;
    entry.last     = seq_end;
  end

  // Fill count and position; cleared after the sequence end
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      symbol_index <= '0;
    end else if (accept) begin
      if (seq_end) begin
        fill_count   <= '0;
        symbol_index <= '0;
      end else begin
        symbol_index <= index_next;
        if (!drop) fill_count <= fill_next;
      end
    end
  end

  // Window shift
  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      codes <= codes_next;
      unk   <= unk_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/kie_cell.sv -----
`default_nettype none
module kie_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [4:0]        radix,
  input  wire logic              in_vld,
  input  wire kie_pkg::kie_item_t in_item,
  output logic                   out_vld,
  output kie_pkg::kie_item_t     out_item
);

  kie_pkg::kie_item_t        item_next;
  logic [kie_pkg::PROD_W-1:0] prod;

  // One saturating Horner step on the head code
  assign prod = kie_pkg::PROD_W'(in_item.acc) * kie_pkg::PROD_W'(radix)
              + kie_pkg::PROD_W'(in_item.codes[0]);

  always_comb begin
    item_next = in_item;
    if (in_item.left != '0) begin
      item_next.left = in_item.left - 1'b1;
      item_next.amb  = in_item.amb | in_item.unk[0];
      if (prod > kie_pkg::PROD_W'(kie_pkg::IDX_MAX)) begin
        item_next.acc = kie_pkg::IDX_MAX;
        item_next.ovf = 1'b1;
      end else begin
        item_next.acc = prod[kie_pkg::ACC_W-1:0];
      end
    end
    // hand the remaining codes on, head first
    for (int j = 0; j < kie_pkg::MAX_WORD - 1; j++) begin
      item_next.codes[j] = in_item.codes[j+1];
      item_next.unk[j]   = in_item.unk[j+1];
    end
    item_next.codes[kie_pkg::MAX_WORD-1] = '0;
    item_next.unk[kie_pkg::MAX_WORD-1]   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= item_next;
  end

endmodule
`default_nettype wire

// ----- tb/kmer_tb_pkg.sv -----
`timescale 1ns / 1ps
package kmer_tb_pkg;
  import kie_pkg::*;

  // Nucleotide one-hot bytes, in code order
  localparam logic [7:0] NUC_A = 8'd1;
  localparam logic [7:0] NUC_C = 8'd2;
  localparam logic [7:0] NUC_G = 8'd4;
  localparam logic [7:0] NUC_T = 8'd8;

  // Reduced table modes (3 acts as 2)
  localparam logic [1:0] MODE_REDUCED     = 2'd2;
  localparam logic [1:0] MODE_REDUCED_ALT = 2'd3;

  // Amino letters in rank order
  localparam string AMINO_ORDER = "ARNDCQEGHILKMFPSTWYV";

  localparam int PRINT_CAP = 100;

  typedef struct {
    bit [30:0] kmer_value;
    bit        ambiguous;
    bit        overflowed;
    bit [31:0] position;
    bit        seq_last;
  } kmer_result_t;

  class kmer_scoreboard;
    // register copies
    bit [4:0]  word_size;
    bit [4:0]  radix;
    bit [1:0]  alphabet;
    bit        skip_gaps;
    bit [59:0] map_low;
    bit [39:0] map_high;

    // window state, entry 0 is the newest code
    bit [4:0]    win_code [MAX_WORD];
    bit          win_unk  [MAX_WORD];
    int unsigned fill;
    bit [31:0]   sym_count;

    kmer_result_t expected_kmers[$];
    int unsigned  mismatches;

    function new();
      word_size  = 5'd4;
      radix      = 5'd4;
      alphabet   = MODE_NUCLEOTIDE;
      skip_gaps  = 1'b0;
      map_low    = '0;
      map_high   = '0;
      sym_count  = '0;
      mismatches = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int i = 0; i < MAX_WORD; i++) begin
        win_code[i] = '0;
        win_unk[i]  = 1'b0;
      end
      fill = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_WORD_SIZE:   word_size = data[4:0];
        CFG_RADIX:       radix     = data[4:0];
        CFG_ALPHABET:    alphabet  = data[1:0];
        CFG_SKIP_GAPS:   skip_gaps = data[0];
        CFG_REDUCED_LOW: map_low   = data[59:0];
        CFG_REDUCED_HI:  map_high  = data[39:0];
        default: ;
      endcase
    endfunction

    // word size as the block applies it
    function int unsigned active_word();
      if (word_size == 0) return 1;
      if (word_size > MAX_WORD) return MAX_WORD;
      return word_size;
    endfunction

    function bit is_gap(bit [7:0] s);
      if (alphabet == MODE_NUCLEOTIDE) return s == NUC_GAP_A || s == NUC_GAP_B;
      return s == AMINO_GAP_A || s == AMINO_GAP_B;
    endfunction

    // letter code of a byte; returns 0 for an unknown letter (code 0 then)
    function bit map_byte(bit [7:0] s, output bit [4:0] code);
      code = '0;
      if (alphabet == MODE_NUCLEOTIDE) begin
        case (s)
          NUC_A: code = 5'd0;
          NUC_C: code = 5'd1;
          NUC_G: code = 5'd2;
          NUC_T: code = 5'd3;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      for (int r = 0; r < 20; r++) begin
        if (AMINO_ORDER[r] == s) begin
          if (alphabet == MODE_AMINO) code = 5'(r);
          else if (r < 12) code = map_low[5*r +: 5];
          else code = map_high[5*(r-12) +: 5];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // accepted symbol request: advance the window and queue any index
    function void note_symbol(bit [7:0] s, bit last);
      bit [4:0]          code;
      bit                known, amb, ovf;
      longint unsigned   acc;
      int unsigned       ws;
      kmer_result_t      r;
      ws = active_word();
      if (sym_count != '1) sym_count++;
      if (!(skip_gaps && is_gap(s))) begin
        known = map_byte(s, code);
        for (int i = MAX_WORD - 1; i > 0; i--) begin
          win_code[i] = win_code[i-1];
          win_unk[i]  = win_unk[i-1];
        end
        win_code[0] = code;
        win_unk[0]  = !known;
        if (fill < MAX_WORD) fill++;
        if (fill >= ws) begin
          acc = 0;
          amb = 1'b0;
          ovf = 1'b0;
          // Horner from newest to oldest, saturating at each step
          for (int i = 0; i < ws; i++) begin
            amb |= win_unk[i];
            acc = acc * radix + win_code[i];
            if (acc > 64'(IDX_MAX)) begin
              ovf = 1'b1;
              acc = 64'(IDX_MAX);
            end
          end
          if (amb) begin
            acc = 0;
            ovf = 1'b0;
          end
          r.kmer_value = acc[30:0];
          r.ambiguous  = amb;
          r.overflowed = ovf;
          r.position   = sym_count;
          r.seq_last   = last;
          expected_kmers.push_back(r);
        end
      end
      if (last) begin
        clear_window();
        sym_count = '0;
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(kmer_result_t got);
      kmer_result_t want;
      if (expected_kmers.size() == 0) begin
        report_mismatch($sformatf("unexpected result, position %0d", got.position));
        return;
      end
      want = expected_kmers.pop_front();
      if (got.kmer_value != want.kmer_value)
        report_mismatch($sformatf("kmer_value %0d, predicted %0d (position %0d)",
                                  got.kmer_value, want.kmer_value, want.position));
      if (got.ambiguous != want.ambiguous)
        report_mismatch($sformatf("ambiguous %0b, predicted %0b (position %0d)",
                                  got.ambiguous, want.ambiguous, want.position));
      if (got.overflowed != want.overflowed)
        report_mismatch($sformatf("overflowed %0b, predicted %0b (position %0d)",
                                  got.overflowed, want.overflowed, want.position));
      if (got.position != want.position)
        report_mismatch($sformatf("position %0d, predicted %0d",
                                  got.position, want.position));
      if (got.seq_last != want.seq_last)
        report_mismatch($sformatf("seq_last %0b, predicted %0b (position %0d)",
                                  got.seq_last, want.seq_last, want.position));
    endtask

    task check_drained();
      if (expected_kmers.size() != 0)
        report_mismatch($sformatf("%0d predicted results never arrived",
                                  expected_kmers.size()));
    endtask
  endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import kie_pkg::*;
  import kmer_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned DRAIN_CYCLES = MAX_WORD + 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol    = '0;
  logic        seq_end   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] kmer_value;
  logic        ambiguous;
  logic        overflowed;
  logic [31:0] position;
  logic        seq_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  kmer_scoreboard sb = new();
  kmer_result_t   seen;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned random_sent    = 0;
  int unsigned cycle_count    = 0;

  always #1 clk = ~clk;

  kmer_index_enumerator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .symbol(symbol), .seq_end(seq_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kmer_value(kmer_value), .ambiguous(ambiguous), .overflowed(overflowed),
    .position(position), .seq_last(seq_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Result side: check accepted results, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.kmer_value = kmer_value;
      seen.ambiguous  = ambiguous;
      seen.overflowed = overflowed;
      seen.position   = position;
      seen.seq_last   = seq_last;
      sb.check_result(seen);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One symbol request; valid is left high for the caller to drop or reuse
  task automatic send_symbol(input logic [7:0] s, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= s;
    seq_end  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_symbol(s, last);
  endtask

  // Random byte for the current alphabet: mostly letters, some gaps and noise
  function automatic logic [7:0] pick_symbol(input int unsigned noise_pct);
    int unsigned r;
    int unsigned gap_pct;
    r = $urandom_range(99);
    gap_pct = sb.skip_gaps ? 8 : (noise_pct != 0 ? 3 : 0);
    if (r < noise_pct) return 8'($urandom_range(255));
    if (r < noise_pct + gap_pct) begin
      if (sb.alphabet == MODE_NUCLEOTIDE)
        return $urandom_range(1) ? NUC_GAP_A : NUC_GAP_B;
      return $urandom_range(1) ? AMINO_GAP_A : AMINO_GAP_B;
    end
    if (sb.alphabet == MODE_NUCLEOTIDE) begin
      case ($urandom_range(3))
        0: return NUC_A;
        1: return NUC_C;
        2: return NUC_G;
        default: return NUC_T;
      endcase
    end
    return AMINO_ORDER[$urandom_range(19)];
  endfunction

  task automatic send_run(input int unsigned len, input bit close,
                          input int unsigned noise_pct);
    for (int unsigned i = 1; i <= len; i++)
      send_symbol(pick_symbol(noise_pct), close && i == len);
    random_sent += len;
  endtask

  // Wait for every predicted result plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_kmers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [4:0] ws, input logic [4:0] rdx,
                                input logic [1:0] mode, input logic skip,
                                input logic [59:0] lo, input logic [39:0] hi);
    settle();
    write_reg(CFG_WORD_SIZE, 64'(ws));
    write_reg(CFG_RADIX, 64'(rdx));
    write_reg(CFG_ALPHABET, 64'(mode));
    write_reg(CFG_SKIP_GAPS, 64'(skip));
    write_reg(CFG_REDUCED_LOW, 64'(lo));
    write_reg(CFG_REDUCED_HI, 64'(hi));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned eff_ws;
    int unsigned len;
    int unsigned noise;
    logic [4:0]  ws, rdx;
    logic [1:0]  mode;
    logic        skip;
    logic [59:0] lo;
    logic [39:0] hi;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, clean nucleotide k-mers
    send_symbol(NUC_A, 1'b0);
    send_symbol(NUC_C, 1'b0);
    send_symbol(NUC_G, 1'b0);
    send_symbol(NUC_T, 1'b0);
    send_symbol(NUC_T, 1'b1);
    // byte extremes and an unskipped gap make the window ambiguous
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(NUC_A, 1'b0);
    send_symbol(NUC_GAP_A, 1'b0);
    send_symbol(NUC_C, 1'b0);
    send_symbol(NUC_G, 1'b0);
    send_symbol(NUC_T, 1'b0);
    send_symbol(NUC_T, 1'b1);
    // skipped gaps still count toward position; a skipped gap can end a sequence
    apply_settings(5'd1, 5'd2, MODE_NUCLEOTIDE, 1'b1, '0, '0);
    send_symbol(NUC_GAP_B, 1'b0);
    send_symbol(NUC_A, 1'b0);
    send_symbol(NUC_GAP_A, 1'b1);
    send_symbol(NUC_C, 1'b1);

    // Random phases, each with its own settings and idling pattern
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      lo = 60'({$urandom, $urandom});
      hi = 40'({$urandom, $urandom});
      case (phase)
        0: begin ws = 5'd20; rdx = 5'd20; mode = MODE_AMINO; skip = 1'b1; end
        1: begin
          ws = 5'd31; rdx = 5'd31; mode = MODE_REDUCED; skip = 1'b0;
          lo = '1; hi = '1;
        end
        2: begin ws = 5'd0; rdx = 5'd0; mode = MODE_REDUCED_ALT; skip = 1'b1; end
        3: begin
          ws = 5'd3; rdx = 5'd1; mode = MODE_NUCLEOTIDE; skip = 1'b0;
          lo = '0; hi = '0;
        end
        4: begin ws = 5'd1; rdx = 5'd2; mode = MODE_AMINO; skip = 1'b0; end
        default: begin
          ws   = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                          : 5'($urandom_range(1, 12));
          rdx  = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                          : 5'($urandom_range(2, 20));
          mode = 2'($urandom_range(3));
          skip = 1'($urandom_range(1));
        end
      endcase
      apply_settings(ws, rdx, mode, skip, lo, hi);

      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 53; end
        default: begin send_gap_pct = 30; recv_stall_pct = 30; end
      endcase

      eff_ws = sb.active_word();
      target = random_sent + PHASE_ITEMS;
      while (random_sent < target) begin
        case ($urandom_range(3))
          0, 1: noise = 0;
          2: noise = 4;
          default: noise = 25;
        endcase
        len = ($urandom_range(99) < 15) ? $urandom_range(1, eff_ws)
                                        : eff_ws + $urandom_range(0, 12);
        send_run(len, 1'b1, noise);
      end
      // leave a sequence open across the next settings change
      if ($urandom_range(1)) send_run($urandom_range(1, 10), 1'b0, 0);
      phase++;
    end

    settle();
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
